// ===== rtl/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date adder.
// No dependencies; imported by gda_ctrl, gda_dp and the top level.
package gda_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 16;
    localparam int SUM_W   = 17;
    localparam int REM_W   = 9;
    localparam int STEP_W  = 3;

    // year is reduced mod 400 by restoring subtraction of 400 << k, k = 5..0
    localparam logic [YEAR_W-1:0] YEAR_CYCLE   = 14'd400;
    localparam logic [STEP_W-1:0] REDUCE_FIRST = 3'd5;
    localparam logic [REM_W-1:0]  REM_LAST     = 9'd399;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_MONTH = 2'd1;
    localparam logic [1:0] STS_BAD_DAY   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } gda_state_t;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic check;
        logic walk_step;
        logic out_load;
    } gda_cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic check_err;
        logic walk_done;
        logic out_free;
    } gda_sts_t;

    // leap test from year mod 400
    function automatic logic is_leap(input logic [REM_W-1:0] r);
        logic div4;
        logic cent;
        div4 = (r[1:0] == 2'd0);
        cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
        return div4 && !cent;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MONTH_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV})
        begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

// ===== rtl/gda_ctrl.sv =====
// Sequencer for the date adder: load, reduce year, validate, walk, deliver.
// Depends on gda_pkg; drives gda_dp through gda_cmd_t.
module gda_ctrl
    import gda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gda_sts_t sts,
    output gda_cmd_t cmd
);

    gda_state_t state_reg;
    gda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (sts.reduce_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.check_err ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_step = !sts.walk_done;
            end
            ST_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/gda_dp.sv =====
// Datapath for the date adder: year mod 400 reduction, validation, month walk
// and the output register. Depends on gda_pkg; commanded by gda_ctrl.
module gda_dp
    import gda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gda_cmd_t             cmd,
    output gda_sts_t             sts,
    input  logic [DAY_W-1:0]     start_day,
    input  logic [MONTH_W-1:0]   start_month,
    input  logic [YEAR_W-1:0]    start_year,
    input  logic [ADD_W-1:0]     days_to_add,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [DAY_W-1:0]     result_day,
    output logic [MONTH_W-1:0]   result_month,
    output logic [YEAR_W-1:0]    result_year
);

    logic [DAY_W-1:0]   sday_reg;
    logic [SUM_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [YEAR_W-1:0]  rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         sts_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         status_reg;
    logic [DAY_W-1:0]   rday_reg;
    logic [MONTH_W-1:0] rmonth_reg;
    logic [YEAR_W-1:0]  ryear_reg;

    logic [YEAR_W-1:0]  sub_val;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               bad_month;
    logic               bad_day;
    logic [1:0]         chk_code;
    logic [REM_W-1:0]   rem_next;

    assign sub_val   = YEAR_CYCLE << step_reg;
    assign leap      = is_leap(rem_reg[REM_W-1:0]);
    assign len       = month_len(month_reg, leap);
    assign bad_month = (month_reg == 4'd0) || (month_reg > MONTH_DEC);
    assign bad_day   = (sday_reg == 5'd0) || (sday_reg > len);
    assign chk_code  = bad_month ? STS_BAD_MONTH : (bad_day ? STS_BAD_DAY : STS_OK);

    // year wrap to 0 lands on a multiple of 400
    always_comb
    begin
        if (year_reg == {YEAR_W{1'b1}} || rem_reg[REM_W-1:0] == REM_LAST)
        begin
            rem_next = '0;
        end
        else
        begin
            rem_next = rem_reg[REM_W-1:0] + 9'd1;
        end
    end

    assign sts.reduce_done = (step_reg == 3'd0);
    assign sts.check_err   = (chk_code != STS_OK);
    assign sts.walk_done   = (day_reg <= SUM_W'(len));
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sday_reg  <= start_day;
            day_reg   <= SUM_W'(start_day) + SUM_W'(days_to_add);
            month_reg <= start_month;
            year_reg  <= start_year;
            rem_reg   <= start_year;
            step_reg  <= REDUCE_FIRST;
        end
        else if (cmd.reduce_step)
        begin
            if (rem_reg >= sub_val)
            begin
                rem_reg <= rem_reg - sub_val;
            end
            step_reg <= step_reg - 3'd1;
        end
        else if (cmd.check)
        begin
            sts_reg <= chk_code;
        end
        else if (cmd.walk_step)
        begin
            day_reg <= day_reg - SUM_W'(len);
            if (month_reg == MONTH_DEC)
            begin
                month_reg <= MONTH_JAN;
                year_reg  <= year_reg + 14'd1;
                rem_reg   <= YEAR_W'(rem_next);
            end
            else
            begin
                month_reg <= month_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= sts_reg;
            if (sts_reg == STS_OK)
            begin
                rday_reg   <= day_reg[DAY_W-1:0];
                rmonth_reg <= month_reg;
                ryear_reg  <= year_reg;
            end
            else
            begin
                rday_reg   <= '0;
                rmonth_reg <= '0;
                ryear_reg  <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_day   = rday_reg;
    assign result_month = rmonth_reg;
    assign result_year  = ryear_reg;

    // year residue is fully reduced before any month is walked
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (rem_reg < 14'd400))
        else $error("year residue not reduced during walk");

    // walking only happens on a validated month
    a_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (month_reg >= MONTH_JAN && month_reg <= MONTH_DEC))
        else $error("walk on invalid month");

    // each walk step strictly shrinks the remaining day count
    a_day_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |=> (day_reg < $past(day_reg)))
        else $error("day count did not shrink");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

endmodule

// ===== rtl/gregorian_date_add_days_top.sv =====
// Top level of the Gregorian date adder: stream ports, field unpacking,
// controller and datapath. Depends on gda_pkg, gda_ctrl and gda_dp.

// Adds a day count to a Gregorian date, one item at a time. An item is taken
// only while the block is idle; its result then sits in an output register,
// so the next item can be taken while that result waits for the consumer.
// Each item passes through these steps, where M is the number of month
// boundaries crossed (up to roughly 2160 for the largest day count): a load
// step, six steps of restoring subtraction that reduce the year mod 400 for
// the leap rule, a validation step, M steps of the month walk
// (the walk loop subtracts one month length per cycle), a final compare and
// a move of the result into the output register. Invalid dates skip the month
// walk and its final compare. Status 1 marks a month outside 1..12, status 2 a day outside
// the month; either way the date fields read zero. Years wrap past 16383 to 0.
module gregorian_date_add_days_top
    import gda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year, [38:23] days_to_add
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] result_day, [8:5] result_month, [22:9] result_year
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    gda_cmd_t cmd;
    gda_sts_t sts;

    logic [1:0]         status;
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;

    // sequencer: owns input handshake and the per-item command schedule
    gda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and the output register
    gda_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .start_day    (s_axis_tdata[4:0]),
        .start_month  (s_axis_tdata[8:5]),
        .start_year   (s_axis_tdata[22:9]),
        .days_to_add  (s_axis_tdata[38:23]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .status       (status),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

    // pad bit keeps tdata byte aligned
    assign m_axis_tdata = {1'b0, result_year, result_month, result_day};
    assign m_axis_tuser = status;

endmodule
